// File: design/dsf_pkg.sv
// ----------------------------------------------------------------------------
// Distance sort filter package
// Shared types and fixed constants of the distance sort filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsf_pkg;

   localparam int OFFSET_WIDTH = 25;
   localparam int LIMIT_WIDTH  = 25;
   localparam int CMD_WIDTH    = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_EMIT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: design/dsf_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of an unsigned radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_isqrt #(
   parameter int RAD_WIDTH = 50
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [RAD_WIDTH-1:0]     radicand,
   output logic                          busy,
   output logic [RAD_WIDTH/2-1:0]        root
);

   localparam int ROOT_W = RAD_WIDTH / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int STEP_W = $clog2(ROOT_W + 1);

   logic [RAD_WIDTH-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic [1:0]           pair;
   logic [REM_W-1:0]     pre;
   logic [REM_W-1:0]     trial;
   logic                 fits;

   always_comb begin
      pair    = rad_ff[RAD_WIDTH-1 -: 2];
      pre     = {rem_ff[REM_W-3:0], pair};
      trial   = REM_W'({root_ff, 2'b01});
      fits    = (pre >= trial);
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = STEP_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? (pre - trial) : pre;
         root_in = {root_ff[ROOT_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// File: design/dsf_cell.sv
// ----------------------------------------------------------------------------
// Sort cell
// One slot of the sorted distance chain. Takes part in ordered insertion
// and in the rotation that streams the chain out past its head.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_cell #(
   parameter int DIST_WIDTH = 25,
   parameter int CNT_WIDTH  = 6,
   parameter int IDX        = 0
) (
   input  wire logic                   clock,
   input  wire dsf_pkg::cell_ctrl_type ctrl,
   input  wire logic [CNT_WIDTH-1:0]   count,
   input  wire logic [DIST_WIDTH-1:0]  new_dist,
   input  wire logic [DIST_WIDTH-1:0]  head_dist,
   input  wire logic [DIST_WIDTH-1:0]  left_dist,
   input  wire logic                   left_gt,
   input  wire logic [DIST_WIDTH-1:0]  right_dist,
   output logic [DIST_WIDTH-1:0]       value,
   output logic                        gt
);

   import dsf_pkg::*;

   logic [DIST_WIDTH-1:0] value_ff, value_in;
   logic                  occupied;
   logic                  at_end;
   logic                  has_right;

   always_comb begin
      occupied  = (CNT_WIDTH'(IDX) < count);
      at_end    = (CNT_WIDTH'(IDX) == count);
      has_right = (CNT_WIDTH'(IDX + 1) < count);
      gt        = occupied && (value_ff > new_dist);
      value_in  = value_ff;
      if (ctrl.insert && (gt || at_end)) begin
         value_in = left_gt ? left_dist : new_dist;
      end else if (ctrl.rotate && occupied) begin
         value_in = has_right ? right_dist : head_dist;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// File: design/distance_sort_filter.sv
// ----------------------------------------------------------------------------
// Distance sort filter
// Keeps distances from a reference position to points in ascending order
// in a chain of cells and streams those at or below a limit on request.
//
//   Channel   Direction  Beat contents
//   req_      in         cmd, plane_x, plane_y, point_x, point_y, limit
//   rsp_      out        offset, last, empty_res, overflow
//
// A clear or an ignored command completes on acceptance. An add passes
// through the square, sum and root states, the last waiting for the square
// root unit that produces one root bit per cycle. An emit rotates the
// chain one step per stored distance, and waits in place while the result
// beat stalls.
// Reset empties the store at once; there is no clearing pass.
// The result register lets a new request beat be taken while a beat waits.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_sort_filter #(
   parameter int CAPACITY    = 32,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [dsf_pkg::CMD_WIDTH-1:0]         req_cmd,
   input  wire logic signed [COORD_WIDTH-1:0]         req_plane_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_plane_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_point_y,
   input  wire logic [dsf_pkg::LIMIT_WIDTH-1:0]       req_limit,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [dsf_pkg::OFFSET_WIDTH-1:0]           rsp_offset,
   output logic                                       rsp_last,
   output logic                                       rsp_empty_res,
   output logic                                       rsp_overflow
);

   import dsf_pkg::*;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int DIST_W = SQ_W / 2;
   localparam int CMP_W  = (DIST_W > LIMIT_WIDTH) ? DIST_W : LIMIT_WIDTH;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic                   any_ff, any_in;
   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [DIFF_W-1:0]      dx_ff, dy_ff;
   logic [SQ_W-1:0]        sx_ff, sy_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_WIDTH-1:0] rsp_offset_ff, rsp_offset_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   accept;
   logic                   out_free;
   logic signed [DIFF_W-1:0] dx_raw, dy_raw;
   logic [DIFF_W-1:0]      dx_abs, dy_abs;
   logic                   sqrt_start;
   logic                   sqrt_busy;
   logic [DIST_W-1:0]      sqrt_root;
   logic                   head_ok;
   logic                   next_ok;
   cell_ctrl_type          ctrl;

   logic [DIST_W-1:0]      cell_value [CAPACITY];
   logic                   cell_gt    [CAPACITY];
   logic [DIST_W-1:0]      left_dist  [CAPACITY];
   logic                   left_gt    [CAPACITY];
   logic [DIST_W-1:0]      right_dist [CAPACITY];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dx_raw = DIFF_W'(req_point_x) - DIFF_W'(req_plane_x);
      dy_raw = DIFF_W'(req_point_y) - DIFF_W'(req_plane_y);
      dx_abs = dx_raw[DIFF_W-1] ? DIFF_W'(-dx_raw) : DIFF_W'(dx_raw);
      dy_abs = dy_raw[DIFF_W-1] ? DIFF_W'(-dy_raw) : DIFF_W'(dy_raw);
   end

   dsf_isqrt #(
      .RAD_WIDTH (SQ_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sx_ff + sy_ff),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            assign left_dist[gi] = '0;
            assign left_gt[gi]   = 1'b0;
         end else begin : g_rest
            assign left_dist[gi] = cell_value[gi-1];
            assign left_gt[gi]   = cell_gt[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_dist[gi] = cell_value[0];
         end else begin : g_inner
            assign right_dist[gi] = cell_value[gi+1];
         end
         dsf_cell #(
            .DIST_WIDTH (DIST_W),
            .CNT_WIDTH  (CNT_W),
            .IDX        (gi)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .new_dist   (sqrt_root),
            .head_dist  (cell_value[0]),
            .left_dist  (left_dist[gi]),
            .left_gt    (left_gt[gi]),
            .right_dist (right_dist[gi]),
            .value      (cell_value[gi]),
            .gt         (cell_gt[gi])
         );
      end
   endgenerate

   assign head_ok = (CMP_W'(cell_value[0]) <= CMP_W'(limit_ff));
   assign next_ok = (CMP_W'(cell_value[1]) <= CMP_W'(limit_ff));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      k_in          = k_ff;
      any_in        = any_ff;
      sqrt_start    = 1'b0;
      ctrl          = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  CMD_ADD: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        ovf_in = 1'b1;
                     end else begin
                        state_in = ST_SQUARE;
                     end
                  end
                  CMD_EMIT: begin
                     k_in     = '0;
                     any_in   = 1'b0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SQUARE: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (!sqrt_busy) begin
               ctrl.insert = 1'b1;
               count_in    = count_ff + CNT_W'(1);
               state_in    = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (k_ff == count_ff) begin
               if (any_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_offset_in = '0;
                  rsp_last_in   = 1'b1;
                  rsp_empty_in  = 1'b1;
                  rsp_ovf_in    = ovf_ff;
                  state_in      = ST_IDLE;
               end
            end else if (head_ok) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_offset_in = OFFSET_WIDTH'(cell_value[0]);
                  rsp_last_in   = (k_ff + CNT_W'(1) == count_ff) || !next_ok;
                  rsp_empty_in  = 1'b0;
                  rsp_ovf_in    = ovf_ff;
                  any_in        = 1'b1;
                  ctrl.rotate   = 1'b1;
                  k_in          = k_ff + CNT_W'(1);
               end
            end else begin
               ctrl.rotate = 1'b1;
               k_in        = k_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         k_ff         <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         k_ff         <= k_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff    <= dx_abs;
         dy_ff    <= dy_abs;
         limit_ff <= req_limit;
      end
      sx_ff         <= dx_ff * dx_ff;
      sy_ff         <= dy_ff * dy_ff;
      rsp_offset_ff <= rsp_offset_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_offset    = rsp_offset_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

`default_nettype wire
